// ----- design/utf8_stream_decoder_macros.svh -----
// ----------------------------------------------------------------------------
// utf8_stream_decoder_macros
// Assertion macros for the checker file of the decoder.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define U8SD_ASSERT_IMPLY(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error("u8sd assertion failed");

// next-cycle implication, disabled while reset is low
`define U8SD_ASSERT_NEXT(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error("u8sd assertion failed");

`endif

// ----- design/u8sd_pkg.sv -----
// ----------------------------------------------------------------------------
// u8sd_pkg
// Types, constants and lead-byte classification for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8sd_pkg;

    localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;
    localparam logic [20:0] CP_MAX         = 21'h10FFFF;
    // code point bits 20:11 of the surrogate block
    localparam logic [9:0]  SURR_HIGH_BITS = 10'h01B;

    localparam logic [7:0]  CONT_LO     = 8'h80;
    localparam logic [7:0]  CONT_HI     = 8'hBF;
    localparam logic [7:0]  LEAD_MIN2   = 8'hC2;
    localparam logic [7:0]  LEAD_MAX2   = 8'hDF;
    localparam logic [7:0]  LEAD_E0     = 8'hE0;
    localparam logic [7:0]  LEAD_ED     = 8'hED;
    localparam logic [7:0]  LEAD_MAX3   = 8'hEF;
    localparam logic [7:0]  LEAD_F0     = 8'hF0;
    localparam logic [7:0]  LEAD_MAX4   = 8'hF3;
    localparam logic [7:0]  LEAD_F4     = 8'hF4;
    localparam logic [7:0]  E0_LO       = 8'hA0;
    localparam logic [7:0]  ED_HI       = 8'h9F;
    localparam logic [7:0]  F0_LO       = 8'h90;
    localparam logic [7:0]  F4_HI       = 8'h8F;

    localparam logic [2:0]  WIDTH_BAD   = 3'd0;
    localparam logic [2:0]  WIDTH_ONE   = 3'd1;
    localparam logic [2:0]  WIDTH_TWO   = 3'd2;
    localparam logic [2:0]  WIDTH_THREE = 3'd3;
    localparam logic [2:0]  WIDTH_FOUR  = 3'd4;

    // lead byte class: sequence width and allowed range of the second byte
    typedef struct packed {
        logic [2:0] width;
        logic [7:0] lo;
        logic [7:0] hi;
    } lead_class_t;

    // one result beat
    typedef struct packed {
        logic [2:0]  byte_width;
        logic        is_error;
        logic [20:0] code_point;
    } result_t;

    localparam result_t RESULT_ERROR = '{byte_width: WIDTH_ONE, is_error: 1'b1,
                                         code_point: CP_REPLACEMENT};

    function automatic lead_class_t classify(input logic [7:0] b);
        lead_class_t c;
        c.lo    = CONT_LO;
        c.hi    = CONT_HI;
        c.width = WIDTH_BAD;
        if (b[7] == 1'b0) begin
            c.width = WIDTH_ONE;
        end else if (b < LEAD_MIN2) begin
            c.width = WIDTH_BAD;
        end else if (b <= LEAD_MAX2) begin
            c.width = WIDTH_TWO;
        end else if (b == LEAD_E0) begin
            c.width = WIDTH_THREE;
            c.lo    = E0_LO;
        end else if (b == LEAD_ED) begin
            c.width = WIDTH_THREE;
            c.hi    = ED_HI;
        end else if (b <= LEAD_MAX3) begin
            c.width = WIDTH_THREE;
        end else if (b == LEAD_F0) begin
            c.width = WIDTH_FOUR;
            c.lo    = F0_LO;
        end else if (b <= LEAD_MAX4) begin
            c.width = WIDTH_FOUR;
        end else if (b == LEAD_F4) begin
            c.width = WIDTH_FOUR;
            c.hi    = F4_HI;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- design/utf8_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Streaming UTF-8 decoder: one byte in per beat, scalar values or U+FFFD out.
// ----------------------------------------------------------------------------
// channel   dir  tdata                                   tlast
// s_axis    in   [7:0] byte_in                           end_of_stream
// m_axis    out  [20:0] code_point, [21] is_error,       last_of_run
//                [24:22] byte_width
//
// one byte is decoded in the cycle it is accepted; its results sit in an
// output register that drains one beat per cycle while m_tready is high
// a byte giving zero or one result sustains one byte per cycle while the output is not stalled
// a byte giving several results (up to four) holds the input until the last beat is being taken
// reset clears the pending sequence and the output register
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_stream_decoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] byte_in
    input  wire logic        s_tlast,   // end_of_stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [20:0] code_point, [21] is_error,
                                        // [24:22] byte_width, [31:25] zero
    output logic             m_tlast    // last_of_run
);
    import u8sd_pkg::*;

    // decoder state
    logic [7:0] lead_reg,  lead_next;
    logic [1:0] pend_reg,  pend_next;
    logic [2:0] width_reg, width_next;
    logic [7:0] tail0_reg, tail0_next;
    logic [7:0] tail1_reg, tail1_next;

    // output register: beats left and the final beat of the run
    logic [2:0] cnt_reg, cnt_next;
    result_t    last_reg;

    logic        s_acc, m_acc;
    lead_class_t cls_in, cls_lead;
    logic [7:0]  lo, hi;
    logic [20:0] cp_asm;
    logic [2:0]  nerr_a, nerr_b, n_res;
    logic        fin_vld, take_lead;
    result_t     fin, last_res, beat;

    assign s_acc = s_tvalid & s_tready;
    assign m_acc = m_tvalid & m_tready;

    // input free once the output register is empty or its last beat is being taken
    assign s_tready = (cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && m_tready);

    // code point assembly from lead, tails and the closing byte
    always_comb begin
        unique case (width_reg)
            WIDTH_TWO: begin
                cp_asm = {10'd0, lead_reg[4:0], s_tdata[5:0]};
            end
            WIDTH_THREE: begin
                cp_asm = {5'd0, lead_reg[3:0], tail0_reg[5:0], s_tdata[5:0]};
            end
            default: begin
                cp_asm = {lead_reg[2:0], tail0_reg[5:0], tail1_reg[5:0], s_tdata[5:0]};
            end
        endcase
    end

    // decode one byte against the pending sequence
    always_comb begin
        cls_in     = classify(s_tdata);
        cls_lead   = classify(lead_reg);
        lo         = (pend_reg == 2'd1) ? cls_lead.lo : CONT_LO;
        hi         = (pend_reg == 2'd1) ? cls_lead.hi : CONT_HI;
        lead_next  = lead_reg;
        pend_next  = pend_reg;
        width_next = width_reg;
        tail0_next = tail0_reg;
        tail1_next = tail1_reg;
        nerr_a     = 3'd0;
        nerr_b     = 3'd0;
        fin_vld    = 1'b0;
        fin        = RESULT_ERROR;
        take_lead  = 1'b0;

        if (pend_reg == 2'd0) begin
            take_lead = 1'b1;
        end else if ((s_tdata >= lo) && (s_tdata <= hi)) begin
            if (({1'b0, pend_reg} + 3'd1) >= width_reg) begin
                fin_vld        = 1'b1;
                fin.code_point = cp_asm;
                fin.is_error   = 1'b0;
                fin.byte_width = width_reg;
                pend_next      = 2'd0;
                width_next     = WIDTH_ONE;
            end else begin
                if (pend_reg == 2'd1) begin
                    tail0_next = s_tdata;
                end else begin
                    tail1_next = s_tdata;
                end
                pend_next = pend_reg + 2'd1;
            end
        end else begin
            // bad continuation: lead and tails fail, byte retried as a lead
            nerr_a     = {1'b0, pend_reg};
            pend_next  = 2'd0;
            width_next = WIDTH_ONE;
            take_lead  = 1'b1;
        end

        // new lead
        if (take_lead) begin
            if (cls_in.width == WIDTH_ONE) begin
                fin_vld        = 1'b1;
                fin.code_point = {13'd0, s_tdata};
                fin.is_error   = 1'b0;
                fin.byte_width = WIDTH_ONE;
            end else if (cls_in.width == WIDTH_BAD) begin
                fin_vld = 1'b1;
                fin     = RESULT_ERROR;
            end else begin
                lead_next  = s_tdata;
                width_next = cls_in.width;
                pend_next  = 2'd1;
            end
        end

        // end of stream flushes a truncated sequence
        if (s_tlast && (pend_next != 2'd0)) begin
            nerr_b     = {1'b0, pend_next};
            pend_next  = 2'd0;
            width_next = WIDTH_ONE;
        end

        n_res    = nerr_a + {2'd0, fin_vld} + nerr_b;
        last_res = ((nerr_b != 3'd0) || !fin_vld) ? RESULT_ERROR : fin;
    end

    // beat count of the output register
    always_comb begin
        cnt_next = cnt_reg;
        if (m_acc) begin
            cnt_next = cnt_reg - 3'd1;
        end
        if (s_acc && (n_res != 3'd0)) begin
            cnt_next = n_res;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lead_reg  <= 8'd0;
            pend_reg  <= 2'd0;
            width_reg <= WIDTH_ONE;
            cnt_reg   <= 3'd0;
        end else begin
            cnt_reg <= cnt_next;
            if (s_acc) begin
                lead_reg  <= lead_next;
                pend_reg  <= pend_next;
                width_reg <= width_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            tail0_reg <= tail0_next;
            tail1_reg <= tail1_next;
            if (n_res != 3'd0) begin
                last_reg <= last_res;
            end
        end
    end

    // all beats before the last of a run are errors
    assign beat     = (cnt_reg == 3'd1) ? last_reg : RESULT_ERROR;
    assign m_tvalid = (cnt_reg != 3'd0);
    assign m_tlast  = (cnt_reg == 3'd1);
    assign m_tdata  = {7'd0, beat};

endmodule

`default_nettype wire

// ----- design/u8sd_checker.sv -----
// ----------------------------------------------------------------------------
// u8sd_checker
// Port-level checks of the UTF-8 stream decoder, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf8_stream_decoder_macros.svh"

module u8sd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [7:0]  s_tdata,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tlast
);
    import u8sd_pkg::*;

    logic unused_in;
    assign unused_in = s_tvalid ^ s_tready ^ s_tlast ^ (^s_tdata);

    // a stalled result beat holds
    `U8SD_ASSERT_NEXT(a_m_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // error beats carry the replacement value with width one
    `U8SD_ASSERT_IMPLY(a_err_form, aclk, aresetn, m_tvalid && m_tdata[21], (m_tdata[20:0] == CP_REPLACEMENT) && (m_tdata[24:22] == WIDTH_ONE))

    // only the final beat of a run may be a decoded value
    `U8SD_ASSERT_IMPLY(a_err_before_last, aclk, aresetn, m_tvalid && !m_tlast, m_tdata[21])

    // decoded values are scalar values
    `U8SD_ASSERT_IMPLY(a_scalar, aclk, aresetn, m_tvalid && !m_tdata[21], (m_tdata[20:0] <= CP_MAX) && (m_tdata[20:11] != SURR_HIGH_BITS))

endmodule

bind utf8_stream_decoder u8sd_checker u_u8sd_checker (.*);

`default_nettype wire
